// File: hdl/psrgi_pkg.sv
// ----------------------------------------------------------------------------
// psrgi_pkg
// Shared types and constants for the pedal, steer and gear interlock unit.
// ----------------------------------------------------------------------------
package psrgi_pkg;

    typedef enum logic [1:0] {
        GEAR_P = 2'd0,
        GEAR_R = 2'd1,
        GEAR_N = 2'd2,
        GEAR_D = 2'd3
    } gear_t;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_LKS    = 3'd1,
        MODE_HWC    = 3'd2,
        MODE_TJC    = 3'd3,
        MODE_ACC    = 3'd4,
        MODE_TJA    = 3'd5,
        MODE_AEB    = 3'd6,
        MODE_MANUAL = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        CFG_THROTTLE_STEP     = 3'd0,
        CFG_BRAKE_STEP        = 3'd1,
        CFG_STEER_STEP        = 3'd2,
        CFG_SHIFT_SPEED_LIMIT = 3'd3,
        CFG_AEB_RELEASE_LEVEL = 3'd4,
        CFG_AEB_PRESS_LEVEL   = 3'd5,
        CFG_BRAKE_CANCEL      = 3'd6,
        CFG_THROTTLE_OVERRIDE = 3'd7
    } cfg_idx_t;

    localparam int LEVEL_W   = 7;
    localparam int STEER_W   = 8;
    localparam int SPEED_W   = 12;
    localparam int LIMIT_W   = 10;
    localparam int CFG_DATA_W = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    // Gear request bits.
    localparam int GK_PARK    = 0;
    localparam int GK_REVERSE = 1;
    localparam int GK_NEUTRAL = 2;
    localparam int GK_DRIVE   = 3;

    // Register values after reset.
    localparam logic [LEVEL_W-1:0] RST_THROTTLE_STEP     = 7'd10;
    localparam logic [LEVEL_W-1:0] RST_BRAKE_STEP        = 7'd20;
    localparam logic [LEVEL_W-1:0] RST_STEER_STEP        = 7'd3;
    localparam logic [LIMIT_W-1:0] RST_SHIFT_SPEED_LIMIT = 10'd20;
    localparam logic [LEVEL_W-1:0] RST_AEB_RELEASE_LEVEL = 7'd6;
    localparam logic [LEVEL_W-1:0] RST_AEB_PRESS_LEVEL   = 7'd12;
    localparam logic [LEVEL_W-1:0] RST_BRAKE_CANCEL      = 7'd10;
    localparam logic [LEVEL_W-1:0] RST_THROTTLE_OVERRIDE = 7'd30;

    typedef struct packed {
        logic                      throttle_key;
        logic                      brake_key;
        logic                      left_key;
        logic                      right_key;
        logic [3:0]                gear_keys;
        mode_t                     drive_mode;
        gear_t                     gear_now;
        logic signed [SPEED_W-1:0] speed;
    } tick_t;

    typedef struct packed {
        logic                      steer_valid;
        logic signed [STEER_W-1:0] steer_cmd;
        logic                      pedal_valid;
        logic [LEVEL_W-1:0]        throttle_cmd;
        logic [LEVEL_W-1:0]        brake_cmd;
        logic [LEVEL_W-1:0]        throttle_level;
        logic [LEVEL_W-1:0]        brake_level;
        logic signed [STEER_W-1:0] steer_level;
        logic                      gear_cmd_valid;
        gear_t                     gear_cmd;
        logic                      aeb_takeover;
        logic                      assist_cancel;
    } result_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] throttle_step;
        logic [LEVEL_W-1:0] brake_step;
        logic [LEVEL_W-1:0] steer_step;
        logic [LIMIT_W-1:0] shift_speed_limit;
        logic [LEVEL_W-1:0] aeb_release_level;
        logic [LEVEL_W-1:0] aeb_press_level;
        logic [LEVEL_W-1:0] brake_cancel_level;
        logic [LEVEL_W-1:0] throttle_override_level;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]        throttle_ramp;
        logic [LEVEL_W-1:0]        brake_ramp;
        logic signed [STEER_W-1:0] steer_ramp;
        logic                      idle_pending;
        logic                      aeb_throttle_released;
        logic                      aeb_was_active;
        gear_t                     last_gear;
    } state_t;

endpackage

// File: hdl/psrgi_tick_if.sv
// ----------------------------------------------------------------------------
// psrgi_tick_if
// Valid/ready channel carrying one control tick.
// ----------------------------------------------------------------------------
interface psrgi_tick_if;
    logic             valid;
    logic             ready;
    psrgi_pkg::tick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/psrgi_result_if.sv
// ----------------------------------------------------------------------------
// psrgi_result_if
// Valid/ready channel carrying one command result.
// ----------------------------------------------------------------------------
interface psrgi_result_if;
    logic               valid;
    logic               ready;
    psrgi_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/psrgi_cfg_if.sv
// ----------------------------------------------------------------------------
// psrgi_cfg_if
// Register write channel: index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface psrgi_cfg_if;
    logic                                  valid;
    logic                                  ready;
    psrgi_pkg::cfg_idx_t                   index;
    logic [psrgi_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/psrgi_cfg.sv
// ----------------------------------------------------------------------------
// psrgi_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module psrgi_cfg (
    input  logic              clk,
    input  logic              rst_n,
    psrgi_cfg_if.sink         cfg,
    output psrgi_pkg::cfg_t   cfg_q
);

    psrgi_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_step           <= psrgi_pkg::RST_THROTTLE_STEP;
            cfg_reg.brake_step              <= psrgi_pkg::RST_BRAKE_STEP;
            cfg_reg.steer_step              <= psrgi_pkg::RST_STEER_STEP;
            cfg_reg.shift_speed_limit       <= psrgi_pkg::RST_SHIFT_SPEED_LIMIT;
            cfg_reg.aeb_release_level       <= psrgi_pkg::RST_AEB_RELEASE_LEVEL;
            cfg_reg.aeb_press_level         <= psrgi_pkg::RST_AEB_PRESS_LEVEL;
            cfg_reg.brake_cancel_level      <= psrgi_pkg::RST_BRAKE_CANCEL;
            cfg_reg.throttle_override_level <= psrgi_pkg::RST_THROTTLE_OVERRIDE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                psrgi_pkg::CFG_THROTTLE_STEP:
                    cfg_reg.throttle_step <= cfg.data[psrgi_pkg::LEVEL_W-1:0];
                psrgi_pkg::CFG_BRAKE_STEP:
                    cfg_reg.brake_step <= cfg.data[psrgi_pkg::LEVEL_W-1:0];
                psrgi_pkg::CFG_STEER_STEP:
                    cfg_reg.steer_step <= cfg.data[psrgi_pkg::LEVEL_W-1:0];
                psrgi_pkg::CFG_SHIFT_SPEED_LIMIT:
                    cfg_reg.shift_speed_limit <= cfg.data[psrgi_pkg::LIMIT_W-1:0];
                psrgi_pkg::CFG_AEB_RELEASE_LEVEL:
                    cfg_reg.aeb_release_level <= cfg.data[psrgi_pkg::LEVEL_W-1:0];
                psrgi_pkg::CFG_AEB_PRESS_LEVEL:
                    cfg_reg.aeb_press_level <= cfg.data[psrgi_pkg::LEVEL_W-1:0];
                psrgi_pkg::CFG_BRAKE_CANCEL:
                    cfg_reg.brake_cancel_level <= cfg.data[psrgi_pkg::LEVEL_W-1:0];
                psrgi_pkg::CFG_THROTTLE_OVERRIDE:
                    cfg_reg.throttle_override_level <= cfg.data[psrgi_pkg::LEVEL_W-1:0];
            endcase
        end
    end

endmodule

// File: hdl/psrgi_step.sv
// ----------------------------------------------------------------------------
// psrgi_step
// Per-tick logic: ramps, mode gating, gear interlock, takeover and cancel.
// ----------------------------------------------------------------------------
module psrgi_step (
    input  psrgi_pkg::tick_t   tick_q,
    input  psrgi_pkg::state_t  st,
    input  psrgi_pkg::cfg_t    cfg_q,
    output psrgi_pkg::state_t  st_next,
    output psrgi_pkg::result_t res
);

    logic                idle;
    logic                steer_gate;
    logic                pedal_gate;
    logic [7:0]          thr_sum;
    logic [7:0]          brk_sum;
    logic [6:0]          thr_new;
    logic [6:0]          brk_new;
    logic signed [8:0]   steer_ext;
    logic signed [8:0]   step_ext;
    logic signed [8:0]   steer_raw;
    logic signed [8:0]   steer_sat;
    logic signed [12:0]  spd;
    logic signed [12:0]  lim;
    logic signed [12:0]  aspd;
    logic                stopped;
    logic                rev_ok;
    logic                drv_ok;
    logic                park_ok;
    logic                rel_base;

    always_comb
    begin
        idle = !(tick_q.throttle_key || tick_q.brake_key || tick_q.left_key
                 || tick_q.right_key) && (tick_q.gear_keys == 4'd0);
        steer_gate = (tick_q.drive_mode >= psrgi_pkg::MODE_ACC);
        pedal_gate = (tick_q.drive_mode == psrgi_pkg::MODE_LKS)
                  || (tick_q.drive_mode == psrgi_pkg::MODE_MANUAL);

        // Pedal ramps with saturation at the top of the range.
        thr_sum = {1'b0, st.throttle_ramp} + {1'b0, cfg_q.throttle_step};
        brk_sum = {1'b0, st.brake_ramp} + {1'b0, cfg_q.brake_step};
        thr_new = (thr_sum > {1'b0, psrgi_pkg::LEVEL_MAX}) ? psrgi_pkg::LEVEL_MAX
                                                           : thr_sum[6:0];
        brk_new = (brk_sum > {1'b0, psrgi_pkg::LEVEL_MAX}) ? psrgi_pkg::LEVEL_MAX
                                                           : brk_sum[6:0];

        // Steer: a reversal snaps to centre before ramping again.
        steer_ext = {st.steer_ramp[7], st.steer_ramp};
        step_ext  = signed'({2'b00, cfg_q.steer_step});
        if (tick_q.left_key)
            steer_raw = (st.steer_ramp > 8'sd0) ? 9'sd0 : steer_ext - step_ext;
        else if (tick_q.right_key)
            steer_raw = (st.steer_ramp < 8'sd0) ? 9'sd0 : steer_ext + step_ext;
        else
            steer_raw = 9'sd0;
        if (steer_raw > 9'sd100)
            steer_sat = 9'sd100;
        else if (steer_raw < -9'sd100)
            steer_sat = -9'sd100;
        else
            steer_sat = steer_raw;

        // Gear interlock.
        spd     = {tick_q.speed[11], tick_q.speed};
        lim     = signed'({3'b000, cfg_q.shift_speed_limit});
        aspd    = spd[12] ? -spd : spd;
        stopped = (aspd <= lim);
        park_ok = stopped;
        rev_ok  = (tick_q.gear_now == psrgi_pkg::GEAR_N) ? !(spd > lim)
                : ((tick_q.gear_now != psrgi_pkg::GEAR_R) && stopped);
        drv_ok  = (tick_q.gear_now == psrgi_pkg::GEAR_N) ? !(spd < -lim)
                : ((tick_q.gear_now != psrgi_pkg::GEAR_D) && stopped);

        st_next = st;
        res     = '0;
        res.gear_cmd = psrgi_pkg::GEAR_P;

        if (idle)
        begin
            if (st.idle_pending)
            begin
                st_next.throttle_ramp = '0;
                st_next.brake_ramp    = '0;
                st_next.steer_ramp    = '0;
                st_next.idle_pending  = 1'b0;
                res.steer_valid       = steer_gate;
                res.pedal_valid       = pedal_gate;
            end
        end
        else
        begin
            st_next.idle_pending  = 1'b1;
            st_next.throttle_ramp = tick_q.throttle_key ? thr_new : '0;
            st_next.brake_ramp    = tick_q.brake_key ? brk_new : '0;
            st_next.steer_ramp    = signed'(steer_sat[7:0]);

            if (steer_gate)
            begin
                res.steer_valid = 1'b1;
                res.steer_cmd   = st_next.steer_ramp;
            end
            if (pedal_gate)
            begin
                res.pedal_valid = 1'b1;
                if (tick_q.gear_now != psrgi_pkg::GEAR_P)
                begin
                    res.throttle_cmd = st_next.throttle_ramp;
                    res.brake_cmd    = st_next.brake_ramp;
                end
            end

            // Highest passing request wins.
            if (tick_q.gear_keys[psrgi_pkg::GK_DRIVE] && drv_ok)
            begin
                res.gear_cmd_valid = 1'b1;
                res.gear_cmd       = psrgi_pkg::GEAR_D;
            end
            else if (tick_q.gear_keys[psrgi_pkg::GK_NEUTRAL])
            begin
                res.gear_cmd_valid = 1'b1;
                res.gear_cmd       = psrgi_pkg::GEAR_N;
            end
            else if (tick_q.gear_keys[psrgi_pkg::GK_REVERSE] && rev_ok)
            begin
                res.gear_cmd_valid = 1'b1;
                res.gear_cmd       = psrgi_pkg::GEAR_R;
            end
            else if (tick_q.gear_keys[psrgi_pkg::GK_PARK] && park_ok)
            begin
                res.gear_cmd_valid = 1'b1;
                res.gear_cmd       = psrgi_pkg::GEAR_P;
            end
        end

        // Emergency brake takeover, using the levels after this tick.
        rel_base = st.aeb_was_active && st.aeb_throttle_released;
        if (tick_q.drive_mode == psrgi_pkg::MODE_AEB)
        begin
            st_next.aeb_throttle_released = rel_base
                || (st_next.throttle_ramp < cfg_q.aeb_release_level);
            res.aeb_takeover = (tick_q.gear_now == psrgi_pkg::GEAR_P)
                || (tick_q.gear_now == psrgi_pkg::GEAR_R)
                || (st_next.aeb_throttle_released
                    && (st_next.throttle_ramp > cfg_q.aeb_press_level));
        end
        else
        begin
            st_next.aeb_throttle_released = 1'b0;
        end

        // Assist cancellation in the assisted modes.
        if ((tick_q.drive_mode >= psrgi_pkg::MODE_LKS)
            && (tick_q.drive_mode <= psrgi_pkg::MODE_TJA))
        begin
            res.assist_cancel =
                ((st.last_gear == psrgi_pkg::GEAR_D)
                 && (tick_q.gear_now != psrgi_pkg::GEAR_D))
                || (st_next.brake_ramp > cfg_q.brake_cancel_level)
                || ((tick_q.drive_mode >= psrgi_pkg::MODE_HWC)
                    && (st_next.throttle_ramp > cfg_q.throttle_override_level));
        end

        st_next.aeb_was_active = (tick_q.drive_mode == psrgi_pkg::MODE_AEB);
        st_next.last_gear      = tick_q.gear_now;

        res.throttle_level = st_next.throttle_ramp;
        res.brake_level    = st_next.brake_ramp;
        res.steer_level    = st_next.steer_ramp;
    end

endmodule

// File: hdl/pedal_steer_ramp_gear_interlock_unit.sv
// ----------------------------------------------------------------------------
// pedal_steer_ramp_gear_interlock_unit
// Drive-by-key pedal and steer ramps with mode gating and a gear interlock.
// ----------------------------------------------------------------------------
// Usage notes.
// The tick channel carries one control tick per transfer: the held keys, the
// one-shot gear requests, the driving mode, the current gear and the speed.
// Every tick produces exactly one transfer on the cmd channel, holding the
// gated commands, the ramp levels after the tick, any gear command and the
// takeover and cancel flags. The cfg channel writes one register per
// transfer and is always ready; it should only be used while no tick is in
// flight.
// A tick is captured in the input register on its transfer; its result
// lands in the output register, shown on cmd, once that register is free.
// The ramp state is updated on that same edge, so the next tick sees it with
// no gap, and one tick is taken every cycle while cmd is not stalled.
// When the receiver stalls cmd, the result is held and the input register
// still takes one more tick; tick.ready drops only once both registers are
// full, and rises again in the cycle the result is taken.
// Reset clears both registers, zeroes the ramps, sets the owed zero command
// for the first idle tick, selects Park as the last gear and loads the
// register defaults.
// ----------------------------------------------------------------------------
module pedal_steer_ramp_gear_interlock_unit (
    input  logic           clk,
    input  logic           rst_n,
    psrgi_tick_if.sink     tick,
    psrgi_result_if.source cmd,
    psrgi_cfg_if.sink      cfg
);

    psrgi_pkg::cfg_t    cfg_q;
    psrgi_pkg::state_t  state_reg;
    psrgi_pkg::state_t  state_next;
    psrgi_pkg::tick_t   tick_data_reg;
    logic               tick_valid_reg;
    psrgi_pkg::result_t res_next;
    psrgi_pkg::result_t res_data_reg;
    logic               res_valid_reg;
    logic               advance;
    logic               tick_take;

    psrgi_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    psrgi_step u_step (
        .tick_q  (tick_data_reg),
        .st      (state_reg),
        .cfg_q   (cfg_q),
        .st_next (state_next),
        .res     (res_next)
    );

    // A held tick moves on whenever the output register is empty or is
    // being emptied by a transfer this cycle.
    assign advance   = tick_valid_reg && (!res_valid_reg || cmd.ready);
    assign tick.ready = !tick_valid_reg || advance;
    assign tick_take = tick.valid && tick.ready;

    assign cmd.valid = res_valid_reg;
    assign cmd.data  = res_data_reg;

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            tick_data_reg <= tick.data;
        end
        if (advance)
        begin
            res_data_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg.throttle_ramp         <= '0;
            state_reg.brake_ramp            <= '0;
            state_reg.steer_ramp            <= '0;
            state_reg.idle_pending          <= 1'b1;
            state_reg.aeb_throttle_released <= 1'b0;
            state_reg.aeb_was_active        <= 1'b0;
            state_reg.last_gear             <= psrgi_pkg::GEAR_P;
        end
        else
        begin
            tick_valid_reg <= tick_take || (tick_valid_reg && !advance);
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (cmd.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/psrgi_checker.sv
// ----------------------------------------------------------------------------
// psrgi_checker
// Port-level checks on the command channel, bound to the top level.
// ----------------------------------------------------------------------------
module psrgi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input psrgi_pkg::result_t cmd_data
);

    // A stalled result stays offered.
    a_valid_hold : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("cmd valid dropped while stalled");

    // A stalled result does not change.
    a_data_hold : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> $stable(cmd_data))
        else $error("cmd data changed while stalled");

    // Levels stay inside their saturation bounds.
    a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd_data.throttle_level <= psrgi_pkg::LEVEL_MAX)
                   && (cmd_data.brake_level <= psrgi_pkg::LEVEL_MAX)
                   && (cmd_data.steer_level <= 8'sd100)
                   && (cmd_data.steer_level >= -8'sd100))
        else $error("ramp level out of range");

    // A non-zero throttle command is a gated copy of the throttle level.
    a_thr_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd_data.throttle_cmd != '0)
        |-> cmd_data.pedal_valid
            && (cmd_data.throttle_cmd == cmd_data.throttle_level))
        else $error("throttle command not consistent with its level");

    // Unsent steer and gear commands read as zero.
    a_unsent_zero : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd_data.steer_valid || (cmd_data.steer_cmd == 8'sd0))
                   && (cmd_data.gear_cmd_valid
                       || (cmd_data.gear_cmd == psrgi_pkg::GEAR_P)))
        else $error("unsent command field not zero");

endmodule

bind pedal_steer_ramp_gear_interlock_unit psrgi_checker u_psrgi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_data  (cmd.data)
);

// File: test/pedal_steer_ramp_gear_interlock_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_steer_ramp_gear_interlock_unit_test
// Self-checking bench for the pedal, steer and gear interlock unit. Control
// ticks go in on a valid/ready channel with random gaps, commands are taken
// with random stalls, and every command is checked field by field against a
// cycle-free model of the ramps, the mode gating, the gear interlock and the
// emergency-brake and assist flags, over several register settings.
// ----------------------------------------------------------------------------
module pedal_steer_ramp_gear_interlock_unit_test;

    import psrgi_pkg::*;

    // Number of cycles the command side holds off to fill the unit up.
    localparam int HOLD_CYCLES    = 40;
    localparam int PHASES         = 9;
    localparam int TICKS_PER_PHASE = 95;
    localparam int PRESSURE_PHASE = 6;
    localparam int STEADY_PHASE   = 4;

    // Commands that can be read straight off the behaviour: the owed zero
    // command on the first idle tick, and an idle tick that sends nothing.
    localparam result_t ZERO_COMMANDS_SENT =
        '{steer_valid: 1'b1, pedal_valid: 1'b1, gear_cmd: GEAR_P, default: '0};
    localparam result_t NOTHING_SENT = '{gear_cmd: GEAR_P, default: '0};

    typedef struct {
        tick_t   stim;
        bit      known;
        result_t typed;
    } directed_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psrgi_tick_if   tick_ch ();
    psrgi_result_if cmd_ch ();
    psrgi_cfg_if    cfg_ch ();

    pedal_steer_ramp_gear_interlock_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .cmd   (cmd_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copies of the register file, set on each register load, and of the
    // ramp state, kept in step with every tick transfer.
    cfg_t    reg_shadow;
    state_t  ramp_state;

    // Commands still owed by the unit, oldest first.
    result_t pending_commands[$];

    int failure_count = 0;
    int results_seen  = 0;

    // Shared between the tick source and the command sink: steady turns the
    // random idling off on both sides, hold_request asks the sink for one
    // long hold-off.
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    // State of the random driving pattern.
    logic [3:0] held_keys = 4'b0;
    int         key_run   = 0;
    mode_t      cur_mode  = MODE_MANUAL;
    gear_t      vehicle_gear = GEAR_P;

    initial begin
        forever #5 clk = ~clk;
    end

    // A generous ceiling on the whole run; a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic tick_t make_tick(input bit thr, input bit brk, input bit left,
                                        input bit right, input logic [3:0] gk,
                                        input mode_t mode, input gear_t gear,
                                        input int speed);
        tick_t t;
        t.throttle_key = thr;
        t.brake_key    = brk;
        t.left_key     = left;
        t.right_key    = right;
        t.gear_keys    = gk;
        t.drive_mode   = mode;
        t.gear_now     = gear;
        t.speed        = speed[SPEED_W-1:0];
        return t;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Works out the command for one tick and moves the shadow state on.
    function automatic result_t predict_command(input tick_t t);
        result_t r;
        int      thr, brk, str, spd, aspd, lim, top;
        bit      stopped, steer_gate, pedal_gate, idle, aeb, ok, takeover, cancel;
        r    = NOTHING_SENT;
        top  = int'(LEVEL_MAX);
        thr  = int'(ramp_state.throttle_ramp);
        brk  = int'(ramp_state.brake_ramp);
        str  = int'(ramp_state.steer_ramp);
        spd  = int'(t.speed);
        aspd = (spd < 0) ? -spd : spd;
        lim  = int'(reg_shadow.shift_speed_limit);
        stopped    = (aspd <= lim);
        steer_gate = (t.drive_mode >= MODE_ACC);
        pedal_gate = (t.drive_mode == MODE_LKS) || (t.drive_mode == MODE_MANUAL);
        idle = !(t.throttle_key || t.brake_key || t.left_key || t.right_key)
               && (t.gear_keys == 4'b0000);

        if (idle) begin
            // Only the first idle tick after activity sends zeroed commands.
            if (ramp_state.idle_pending) begin
                thr = 0;
                brk = 0;
                str = 0;
                r.steer_valid = steer_gate;
                r.pedal_valid = pedal_gate;
                ramp_state.idle_pending = 1'b0;
            end
        end else begin
            ramp_state.idle_pending = 1'b1;
            thr = t.throttle_key ? clamp(thr + int'(reg_shadow.throttle_step), 0, top) : 0;
            brk = t.brake_key ? clamp(brk + int'(reg_shadow.brake_step), 0, top) : 0;
            // Left wins over right; a reversal drops the level to zero first.
            if (t.left_key)
                str = (str > 0) ? 0 : str - int'(reg_shadow.steer_step);
            else if (t.right_key)
                str = (str < 0) ? 0 : str + int'(reg_shadow.steer_step);
            else
                str = 0;
            str = clamp(str, -top, top);

            if (steer_gate) begin
                r.steer_valid = 1'b1;
                r.steer_cmd   = str[STEER_W-1:0];
            end
            if (pedal_gate) begin
                r.pedal_valid = 1'b1;
                if (t.gear_now != GEAR_P) begin
                    r.throttle_cmd = thr[LEVEL_W-1:0];
                    r.brake_cmd    = brk[LEVEL_W-1:0];
                end
            end

            // Requests are taken lowest bit first, so the highest passing one wins.
            if (t.gear_keys[GK_PARK] && stopped) begin
                r.gear_cmd_valid = 1'b1;
                r.gear_cmd       = GEAR_P;
            end
            if (t.gear_keys[GK_REVERSE]) begin
                ok = (t.gear_now == GEAR_N) ? (spd <= lim) : (t.gear_now != GEAR_R && stopped);
                if (ok) begin
                    r.gear_cmd_valid = 1'b1;
                    r.gear_cmd       = GEAR_R;
                end
            end
            if (t.gear_keys[GK_NEUTRAL]) begin
                r.gear_cmd_valid = 1'b1;
                r.gear_cmd       = GEAR_N;
            end
            if (t.gear_keys[GK_DRIVE]) begin
                ok = (t.gear_now == GEAR_N) ? (spd >= -lim) : (t.gear_now != GEAR_D && stopped);
                if (ok) begin
                    r.gear_cmd_valid = 1'b1;
                    r.gear_cmd       = GEAR_D;
                end
            end
        end

        aeb      = (t.drive_mode == MODE_AEB);
        takeover = 1'b0;
        if (aeb) begin
            if (!ramp_state.aeb_was_active)
                ramp_state.aeb_throttle_released = 1'b0;
            if (t.gear_now == GEAR_P || t.gear_now == GEAR_R)
                takeover = 1'b1;
            if (!ramp_state.aeb_throttle_released && thr < int'(reg_shadow.aeb_release_level))
                ramp_state.aeb_throttle_released = 1'b1;
            if (ramp_state.aeb_throttle_released && thr > int'(reg_shadow.aeb_press_level))
                takeover = 1'b1;
        end else begin
            ramp_state.aeb_throttle_released = 1'b0;
        end

        cancel = 1'b0;
        if (t.drive_mode >= MODE_LKS && t.drive_mode <= MODE_TJA) begin
            if (ramp_state.last_gear == GEAR_D && t.gear_now != GEAR_D)
                cancel = 1'b1;
            if (brk > int'(reg_shadow.brake_cancel_level))
                cancel = 1'b1;
            if (t.drive_mode >= MODE_HWC && thr > int'(reg_shadow.throttle_override_level))
                cancel = 1'b1;
        end

        ramp_state.aeb_was_active = aeb;
        ramp_state.last_gear      = t.gear_now;
        ramp_state.throttle_ramp  = thr[LEVEL_W-1:0];
        ramp_state.brake_ramp     = brk[LEVEL_W-1:0];
        ramp_state.steer_ramp     = str[STEER_W-1:0];

        r.throttle_level = thr[LEVEL_W-1:0];
        r.brake_level    = brk[LEVEL_W-1:0];
        r.steer_level    = str[STEER_W-1:0];
        r.aeb_takeover   = takeover;
        r.assist_cancel  = cancel;
        return r;
    endfunction

    // Random driving: keys are held for runs of ticks, the mode changes now
    // and then, and the current gear mostly follows the last granted shift.
    // About one tick in ten is pure noise.
    function automatic tick_t next_drive_tick();
        logic [31:0]              word;
        logic [$bits(tick_t)-1:0] raw;
        logic [3:0]               gk;
        gear_t                    gear;
        int                       lim, spd;
        if ($urandom_range(0, 9) == 0) begin
            word = $urandom;
            raw  = word[$bits(tick_t)-1:0];
            return tick_t'(raw);
        end
        if (key_run == 0) begin
            key_run   = $urandom_range(1, 12);
            held_keys = ($urandom_range(0, 4) == 0) ? 4'b0000 : 4'($urandom_range(1, 15));
            if ($urandom_range(0, 3) == 0)
                cur_mode = mode_t'(3'($urandom_range(0, 7)));
        end
        key_run--;
        gk   = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(1, 15)) : 4'b0000;
        gear = ($urandom_range(0, 7) == 0) ? gear_t'(2'($urandom_range(0, 3))) : vehicle_gear;
        lim  = int'(reg_shadow.shift_speed_limit);
        case ($urandom_range(0, 2))
            0:       spd = int'($urandom_range(0, 2 * lim + 4)) - lim - 2;
            1:       spd = int'($urandom_range(0, 4000)) - 2000;
            default: spd = int'($urandom_range(0, 10)) - 5;
        endcase
        return make_tick(held_keys[3], held_keys[2], held_keys[1], held_keys[0],
                         gk, cur_mode, gear, spd);
    endfunction

    // Offers one tick after a random gap and records what it should produce
    // once the transfer has taken place. Valid stays high across back-to-back
    // ticks so that it is never lowered and raised in the same step.
    task automatic send_tick(input tick_t t, input bit known, input result_t typed);
        int      gap;
        result_t predicted;
        gap = steady ? 0 : int'($urandom_range(0, 6));
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        do @(posedge clk); while (tick_ch.ready !== 1'b1);
        predicted = predict_command(t);
        pending_commands.push_back(known ? typed : predicted);
        if (predicted.gear_cmd_valid)
            vehicle_gear = predicted.gear_cmd;
        @(negedge clk);
    endtask

    // Stops offering ticks and waits until every owed command has come out,
    // plus a little margin for the pipeline to settle.
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (pending_commands.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Writes all eight registers in index order, one transfer each.
    task automatic load_registers(input cfg_t c);
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] value;
        for (int i = 0; i < 8; i++) begin
            idx   = cfg_idx_t'(3'(i));
            value = '0;
            case (idx)
                CFG_THROTTLE_STEP:     value[LEVEL_W-1:0] = c.throttle_step;
                CFG_BRAKE_STEP:        value[LEVEL_W-1:0] = c.brake_step;
                CFG_STEER_STEP:        value[LEVEL_W-1:0] = c.steer_step;
                CFG_SHIFT_SPEED_LIMIT: value[LIMIT_W-1:0] = c.shift_speed_limit;
                CFG_AEB_RELEASE_LEVEL: value[LEVEL_W-1:0] = c.aeb_release_level;
                CFG_AEB_PRESS_LEVEL:   value[LEVEL_W-1:0] = c.aeb_press_level;
                CFG_BRAKE_CANCEL:      value[LEVEL_W-1:0] = c.brake_cancel_level;
                default:               value[LEVEL_W-1:0] = c.throttle_override_level;
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= value;
            do @(posedge clk); while (cfg_ch.ready !== 1'b1);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        reg_shadow = c;
        @(negedge clk);
    endtask

    function automatic void check_field(input string name, input logic signed [15:0] want,
                                        input logic signed [15:0] got);
        if (got !== want) begin
            failure_count++;
            if (failure_count <= 10)
                $display("command %0d: %s expected %0d, got %0d", results_seen, name, want, got);
        end
    endfunction

    // Command sink: stalls at random, honours one long hold-off on request,
    // and checks each command transfer against the oldest owed command.
    initial begin : command_sink
        int      stall;
        result_t want;
        result_t got;
        cmd_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                // Long hold-off counted here, while the source keeps offering
                // ticks, so the unit fills up and drops tick.ready.
                cmd_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                stall = steady ? 0 : int'($urandom_range(0, 6));
                if (stall > 0) begin
                    cmd_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            cmd_ch.ready <= 1'b1;
            do @(posedge clk); while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1));
            got = cmd_ch.data;
            if (pending_commands.size() == 0) begin
                failure_count++;
                if (failure_count <= 10)
                    $display("command %0d arrived with no tick outstanding", results_seen);
            end else begin
                want = pending_commands.pop_front();
                check_field("steer_valid",    want.steer_valid,    got.steer_valid);
                check_field("steer_cmd",      want.steer_cmd,      got.steer_cmd);
                check_field("pedal_valid",    want.pedal_valid,    got.pedal_valid);
                check_field("throttle_cmd",   want.throttle_cmd,   got.throttle_cmd);
                check_field("brake_cmd",      want.brake_cmd,      got.brake_cmd);
                check_field("throttle_level", want.throttle_level, got.throttle_level);
                check_field("brake_level",    want.brake_level,    got.brake_level);
                check_field("steer_level",    want.steer_level,    got.steer_level);
                check_field("gear_cmd_valid", want.gear_cmd_valid, got.gear_cmd_valid);
                check_field("gear_cmd",       want.gear_cmd,       got.gear_cmd);
                check_field("aeb_takeover",   want.aeb_takeover,   got.aeb_takeover);
                check_field("assist_cancel",  want.assist_cancel,  got.assist_cancel);
            end
            results_seen++;
        end
    end

    // Tick source and overall sequencing: reset, the directed table, then
    // phases of random driving, each under its own register setting.
    initial begin : tick_source
        directed_row_t directed_rows[$];
        cfg_t          settings;
        int            drain;

        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_THROTTLE_STEP;
        cfg_ch.data   = '0;

        // The shadow starts from the state the unit takes in reset.
        reg_shadow = '{RST_THROTTLE_STEP, RST_BRAKE_STEP, RST_STEER_STEP,
                       RST_SHIFT_SPEED_LIMIT, RST_AEB_RELEASE_LEVEL, RST_AEB_PRESS_LEVEL,
                       RST_BRAKE_CANCEL, RST_THROTTLE_OVERRIDE};
        ramp_state = '0;
        ramp_state.idle_pending = 1'b1;
        ramp_state.last_gear    = GEAR_P;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks under the reset register values. Only the two idle
        // ticks straight after reset carry a typed-in command.
        directed_rows = '{
            // First idle tick owes zero commands; the second sends nothing.
            '{make_tick(0, 0, 0, 0, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b1, ZERO_COMMANDS_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b1, NOTHING_SENT},
            // Ramps rising with keys held.
            '{make_tick(1, 1, 0, 1, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(1, 1, 0, 1, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(1, 1, 0, 1, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b0, NOTHING_SENT},
            // Steer reverses through zero, then both keys with left winning.
            '{make_tick(0, 0, 1, 0, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 1, 0, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 1, 1, 4'b0000, MODE_MANUAL, GEAR_D, 0), 1'b0, NOTHING_SENT},
            // Park zeroes the pedal commands while the level still ramps.
            '{make_tick(1, 0, 0, 0, 4'b0000, MODE_MANUAL, GEAR_P, 0), 1'b0, NOTHING_SENT},
            // Gear interlock: all requests at once, then each one at the limits.
            '{make_tick(0, 0, 0, 0, 4'b1111, MODE_MANUAL, GEAR_N, 0), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0001, MODE_MANUAL, GEAR_D, 2000), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0010, MODE_MANUAL, GEAR_N, -2000), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0010, MODE_MANUAL, GEAR_N, 2047), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b1000, MODE_MANUAL, GEAR_N, -2048), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b1000, MODE_MANUAL, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0010, MODE_MANUAL, GEAR_R, 0), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0100, MODE_MANUAL, GEAR_D, -2000), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0011, MODE_MANUAL, GEAR_P, 0), 1'b0, NOTHING_SENT},
            // No mode sends nothing.
            '{make_tick(1, 0, 0, 0, 4'b0000, MODE_NONE, GEAR_D, 0), 1'b0, NOTHING_SENT},
            // Emergency brake: entry, throttle pressed again, reverse takeover.
            '{make_tick(1, 0, 0, 0, 4'b0000, MODE_AEB, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(1, 0, 0, 0, 4'b0000, MODE_AEB, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(1, 0, 0, 0, 4'b0000, MODE_AEB, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0000, MODE_AEB, GEAR_R, 0), 1'b0, NOTHING_SENT},
            // Assist cancel by brake, then by leaving Drive under throttle in HWC.
            '{make_tick(0, 1, 0, 0, 4'b0000, MODE_LKS, GEAR_D, 0), 1'b0, NOTHING_SENT},
            '{make_tick(1, 0, 0, 0, 4'b0000, MODE_HWC, GEAR_N, 0), 1'b0, NOTHING_SENT},
            '{make_tick(0, 0, 0, 0, 4'b0000, MODE_TJA, GEAR_D, 0), 1'b0, NOTHING_SENT}
        };
        foreach (directed_rows[i])
            send_tick(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].typed);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: settings = '{RST_THROTTLE_STEP, RST_BRAKE_STEP, RST_STEER_STEP,
                                RST_SHIFT_SPEED_LIMIT, RST_AEB_RELEASE_LEVEL,
                                RST_AEB_PRESS_LEVEL, RST_BRAKE_CANCEL,
                                RST_THROTTLE_OVERRIDE};
                1: settings = '{7'd100, 7'd100, 7'd100, 10'd1000,
                                7'd100, 7'd100, 7'd100, 7'd100};
                2: settings = '0;
                default: begin
                    settings.throttle_step           = 7'($urandom_range(0, 100));
                    settings.brake_step              = 7'($urandom_range(0, 100));
                    settings.steer_step              = 7'($urandom_range(0, 100));
                    settings.shift_speed_limit       = 10'($urandom_range(0, 1000));
                    settings.aeb_release_level       = 7'($urandom_range(0, 100));
                    settings.aeb_press_level         = 7'($urandom_range(0, 100));
                    settings.brake_cancel_level      = 7'($urandom_range(0, 100));
                    settings.throttle_override_level = 7'($urandom_range(0, 100));
                end
            endcase
            load_registers(settings);
            steady = (phase == STEADY_PHASE) || (phase == PRESSURE_PHASE);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if (phase == PRESSURE_PHASE && n == 10)
                    hold_request = 1'b1;
                // Once in the run the source pauses until the unit has drained.
                if (phase == 3 && n == 50)
                    wait_idle();
                send_tick(next_drive_tick(), 1'b0, NOTHING_SENT);
            end
            wait_idle();
            steady = 1'b0;
        end

        // Drain what is left, with a bound, then give the verdict.
        tick_ch.valid <= 1'b0;
        drain = 0;
        while (pending_commands.size() != 0 && drain < 5000) begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);
        if (pending_commands.size() != 0) begin
            failure_count += pending_commands.size();
            $display("%0d commands never arrived", pending_commands.size());
        end
        if (failure_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
